### sv/cca_pkg.sv
package cca_pkg;

  localparam int NUM_CONNS_DEF = 3;

  // Operation codes carried on the input tuser
  typedef enum logic [2:0] {
    OP_PDU_CHECK   = 3'd0,
    OP_SET_HASH    = 3'd1,
    OP_SET_AWARE   = 3'd2,
    OP_OPEN        = 3'd3,
    OP_WRITE_FEAT  = 3'd4,
    OP_AWARE_QUERY = 3'd5
  } op_t;

  // Awareness states
  localparam logic [1:0] AW_AWARE        = 2'd0;
  localparam logic [1:0] AW_PENDING      = 2'd1;
  localparam logic [1:0] AW_UNAWARE      = 2'd2;
  localparam logic [1:0] AW_HASH_PENDING = 2'd3;

  // Result status codes
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_OUT_OF_SYNC = 3'd1;
  localparam logic [2:0] STS_UNLIKELY    = 3'd2;
  localparam logic [2:0] STS_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] STS_NOT_ALLOWED = 3'd4;

  // ATT protocol constants
  localparam logic [7:0]  OPC_MTU_REQ   = 8'h02;
  localparam logic [7:0]  OPC_VALUE_CNF = 8'h1E;
  localparam logic [7:0]  OPC_READ_TYPE = 8'h08;
  localparam int          OPC_CMD_BIT   = 6;
  localparam logic [15:0] UUID_DB_HASH  = 16'h2B2A;
  localparam logic [7:0]  FEAT_ALL      = 8'h01;
  localparam int          FEAT_ROBUST_BIT = 0;

  // Register indexes (paddr[2])
  localparam logic REG_NOTIFY_EN = 1'b0;
  localparam logic REG_SC_HANDLE = 1'b1;
  localparam int   PADDR_W       = 3;

  typedef struct packed {
    logic        notify_enable;
    logic [15:0] service_changed_handle;
  } cfg_t;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [9:0]  feat_len;
    logic        csf_present;
    logic [7:0]  csf_value;
    logic [1:0]  state_value;
    logic        hash_flag;
    logic [15:0] attr_handle;
    logic [15:0] type_uuid;
    logic [7:0]  att_opcode;
    logic [1:0]  conn_id;
  } in_word_t;

  // Result word, last field in the lowest bits, padded to three bytes
  typedef struct packed {
    logic [6:0] pad;
    logic       hash_done;
    logic       notify;
    logic       hash_active;
    logic [1:0] conn_state;
    logic [7:0] conn_features;
    logic       client_aware;
    logic [2:0] status;
  } out_word_t;

  typedef enum logic {
    CTL_EMPTY,
    CTL_FULL
  } ctl_state_t;

  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

### sv/cca_regs.sv
module cca_regs
  import cca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_NOTIFY_EN: cfg.notify_enable <= pwdata[0];
        REG_SC_HANDLE: cfg.service_changed_handle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NOTIFY_EN: prdata = {31'd0, cfg.notify_enable};
      REG_SC_HANDLE: prdata = {16'd0, cfg.service_changed_handle};
      default:       prdata = '0;
    endcase
  end

endmodule

### sv/cca_ctrl.sv
module cca_ctrl
  import cca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output dp_cmd_t cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    m_tvalid   = 1'b0;
    s_tready   = 1'b0;
    cmd.exec   = 1'b0;
    state_next = state;
    case (state)
      CTL_EMPTY: begin
        s_tready = 1'b1;
        cmd.exec = s_tvalid;
        if (s_tvalid) begin
          state_next = CTL_FULL;
        end
      end
      CTL_FULL: begin
        m_tvalid = 1'b1;
        // refill the result register in the cycle it drains
        s_tready = m_tready;
        cmd.exec = s_tvalid & m_tready;
        if (m_tready && !s_tvalid) begin
          state_next = CTL_EMPTY;
        end
      end
      default: state_next = CTL_EMPTY;
    endcase
  end

endmodule

### sv/cca_dp.sv
module cca_dp
  import cca_pkg::*;
#(
  parameter int NUM_CONNS = NUM_CONNS_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  cfg_t      cfg,
  input  op_t       op,
  input  in_word_t  in_word,
  output out_word_t result
);

  localparam int IDX_W = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;

  logic [1:0] st_tab [NUM_CONNS];
  logic [7:0] ft_tab [NUM_CONNS];
  logic       hash_busy;

  logic [1:0] st_next [NUM_CONNS];
  logic [7:0] ft_next [NUM_CONNS];
  logic       hash_busy_next;

  logic             valid;
  logic [IDX_W+1:0] cid_m1;
  logic [IDX_W-1:0] idx;
  logic [1:0]       cur_st, sel_st;
  logic [7:0]       cur_ft, sel_ft, new_ft;
  logic             is_cmd;
  logic             demote, all_set;
  out_word_t        res_next;

  assign valid  = (in_word.conn_id != 2'd0) && (32'(in_word.conn_id) <= NUM_CONNS);
  assign cid_m1 = {IDX_W'(0), in_word.conn_id} - (IDX_W + 2)'(1);
  assign idx    = cid_m1[IDX_W-1:0];
  assign is_cmd = in_word.att_opcode[OPC_CMD_BIT];
  assign new_ft = in_word.csf_value & FEAT_ALL;

  always_comb begin
    cur_st = AW_UNAWARE;
    cur_ft = '0;
    for (int i = 0; i < NUM_CONNS; i++) begin
      if (valid && idx == IDX_W'(i)) begin
        cur_st = st_tab[i];
        cur_ft = ft_tab[i];
      end
    end
  end

  always_comb begin
    sel_st         = cur_st;
    sel_ft         = cur_ft;
    hash_busy_next = hash_busy;
    demote         = 1'b0;
    all_set        = 1'b0;
    res_next       = '0;
    case (op)
      OP_PDU_CHECK: begin
        if (valid && in_word.att_opcode != OPC_MTU_REQ &&
            in_word.att_opcode != OPC_VALUE_CNF) begin
          if (cur_st == AW_UNAWARE) begin
            if (!is_cmd) begin
              sel_st = AW_PENDING;
            end
            if (is_cmd || cur_ft[FEAT_ROBUST_BIT]) begin
              res_next.status = STS_OUT_OF_SYNC;
            end
          end else if (cur_st == AW_PENDING) begin
            if (!is_cmd) begin
              sel_st = AW_AWARE;
              res_next.notify = cfg.notify_enable;
            end else begin
              res_next.status = STS_OUT_OF_SYNC;
            end
          end
          // a hash read always passes
          if (in_word.att_opcode == OPC_READ_TYPE && in_word.type_uuid == UUID_DB_HASH) begin
            res_next.status = STS_OK;
            if (hash_busy) begin
              sel_st = AW_HASH_PENDING;
            end
          end
        end
      end
      OP_SET_HASH: begin
        if (hash_busy != in_word.hash_flag) begin
          hash_busy_next     = in_word.hash_flag;
          res_next.hash_done = ~in_word.hash_flag;
          demote             = in_word.hash_flag;
        end
      end
      OP_SET_AWARE: begin
        if (in_word.conn_id == 2'd0) begin
          all_set = 1'b1;
        end else begin
          sel_st = in_word.state_value;
        end
      end
      OP_OPEN: begin
        sel_st = in_word.csf_present ? in_word.state_value : AW_AWARE;
        sel_ft = in_word.csf_present ? in_word.csf_value : 8'd0;
      end
      OP_WRITE_FEAT: begin
        if (!valid) begin
          res_next.status = STS_UNLIKELY;
        end else if (in_word.feat_len != 10'd1) begin
          res_next.status = STS_BAD_LENGTH;
        end else if (cur_ft != 8'd0 && new_ft == 8'd0) begin
          res_next.status = STS_NOT_ALLOWED;
        end else begin
          sel_ft = cur_ft | new_ft;
          res_next.notify = cfg.notify_enable;
        end
      end
      OP_AWARE_QUERY: begin
        if (valid) begin
          res_next.client_aware = ~(cur_ft[FEAT_ROBUST_BIT] && cur_st == AW_UNAWARE &&
                                    in_word.attr_handle != cfg.service_changed_handle);
        end
      end
      default: ;
    endcase

    res_next.conn_state = AW_UNAWARE;
    for (int i = 0; i < NUM_CONNS; i++) begin
      st_next[i] = st_tab[i];
      ft_next[i] = ft_tab[i];
      if (demote && st_tab[i] == AW_HASH_PENDING) begin
        st_next[i] = AW_PENDING;
      end
      if (all_set) begin
        st_next[i] = (st_tab[i] == AW_HASH_PENDING) ? AW_PENDING : in_word.state_value;
      end
      if (valid && idx == IDX_W'(i)) begin
        if (op != OP_SET_HASH) begin
          st_next[i] = sel_st;
          ft_next[i] = sel_ft;
        end
        res_next.conn_state    = st_next[i];
        res_next.conn_features = ft_next[i];
      end
    end
    res_next.hash_active = hash_busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_busy <= 1'b0;
      for (int i = 0; i < NUM_CONNS; i++) begin
        st_tab[i] <= AW_AWARE;
        ft_tab[i] <= '0;
      end
    end else if (cmd.exec) begin
      hash_busy <= hash_busy_next;
      for (int i = 0; i < NUM_CONNS; i++) begin
        st_tab[i] <= st_next[i];
        ft_tab[i] <= ft_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= res_next;
    end
  end

endmodule

### sv/att_client_change_awareness_unit.sv
// Client change-awareness tracker for GATT robust caching. Each connection
// keeps a two-bit awareness state and a feature byte; one global flag marks
// a database hash recomputation. Every input word (operation in tuser) gives
// exactly one result word, which reports the addressed connection after the
// update, the hash flag, a notify pulse and a hash-done pulse. The tables
// update in the cycle of acceptance and the result sits in an output
// register, so one word per clock is sustained while the downstream side
// keeps taking results. Registers: notify_enable at byte 0,
// service_changed_handle at byte 4; write them only while no word is in flight.
module att_client_change_awareness_unit
  import cca_pkg::*;
#(
  parameter int NUM_CONNS = NUM_CONNS_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // conn_id, att_opcode, type_uuid, attr_handle, hash_flag, state_value,
  // csf_value, csf_present, feat_len
  input  logic [63:0]        s_tdata,
  // op
  input  logic [2:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // status, client_aware, conn_features, conn_state, hash_active, notify,
  // hash_done, zero pad
  output logic [23:0]        m_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t      cfg;
  dp_cmd_t   cmd;
  out_word_t result;

  cca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cca_dp #(
    .NUM_CONNS (NUM_CONNS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .op      (op_t'(s_tuser)),
    .in_word (in_word_t'(s_tdata)),
    .result  (result)
  );

  assign m_tdata = result;

endmodule
